FILE: sv/dtv_pkg.sv
// shared constants for the display timing validator
// no dependencies; used by display_timing_validator_unit
package dtv_pkg;

  localparam int unsigned PERIOD_W  = 20;
  localparam int unsigned TIM_W     = 13;
  localparam int unsigned PCLK_W    = 41;
  localparam int unsigned VACT_W    = 16;
  localparam int unsigned REFRESH_W = 31;
  localparam int unsigned FRAME_W   = 51;

  // divider datapath
  localparam int unsigned DIVD_W = 64;
  localparam int unsigned DIVS_W = 41;
  localparam int unsigned CNT_W  = 6;

  // bits of dividend handled by each division
  localparam int unsigned LEN_Q = 30;
  localparam int unsigned LEN_A = 41;
  localparam int unsigned LEN_R = 51;
  localparam int unsigned LEN_F = 61;

  localparam logic [29:0] NS_PER_S    = 30'd1000000000;
  localparam logic [30:0] REFRESH_MAX = 31'h7FFF_FFFF;
  localparam logic [9:0]  MILLI       = 10'd1000;

  localparam int unsigned H_MIN_SUM = 11;
  localparam int unsigned ACT_MIN   = 16;

  localparam logic [1:0] KIND_RGB   = 2'd0;
  localparam logic [1:0] KIND_HDMI  = 2'd1;
  localparam logic [1:0] KIND_DSI   = 2'd2;
  localparam logic [1:0] KIND_OTHER = 2'd3;

  localparam logic [1:0] ST_OK   = 2'd0;
  localparam logic [1:0] ST_ZERO = 2'd1;
  localparam logic [1:0] ST_BAD  = 2'd2;

  localparam logic CFG_KIND = 1'b0;
  localparam logic CFG_DSI  = 1'b1;

endpackage

FILE: sv/display_timing_validator_unit.sv
// display timing validator: checks one video mode and derives clock, refresh, frame time
// depends on dtv_pkg

// One mode request is taken while the unit is idle and its result is held on the out_
// channel until taken; the next request is taken after that. A mode runs through one
// bit-serial restoring divider, one quotient bit per cycle, shared by up to four
// divisions: 1e9/period (30 steps), pclk/h_total (41) and x1000/v_total (51), both RGB
// only, and h_total*v_total*1e9/pclk (61).
module display_timing_validator_unit (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           cfg_we,
  input  logic                           cfg_index,
  input  logic [7:0]                     cfg_wdata,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  logic [dtv_pkg::PERIOD_W-1:0]   in_pixel_period_ps,
  input  logic [dtv_pkg::TIM_W-1:0]      in_hsync_len,
  input  logic [dtv_pkg::TIM_W-1:0]      in_vsync_len,
  input  logic [dtv_pkg::TIM_W-1:0]      in_left_margin,
  input  logic [dtv_pkg::TIM_W-1:0]      in_upper_margin,
  input  logic [dtv_pkg::TIM_W-1:0]      in_x_res,
  input  logic [dtv_pkg::TIM_W-1:0]      in_y_res,
  input  logic [dtv_pkg::TIM_W-1:0]      in_right_margin,
  input  logic [dtv_pkg::TIM_W-1:0]      in_lower_margin,
  input  logic                           in_hsync_high_active,
  input  logic                           in_vsync_high_active,
  input  logic                           in_stereo,
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic [1:0]                     out_status,
  output logic [dtv_pkg::PCLK_W-1:0]     out_pclk_hz,
  output logic [dtv_pkg::TIM_W-1:0]      out_h_ref,
  output logic [dtv_pkg::TIM_W-1:0]      out_v_ref,
  output logic [dtv_pkg::VACT_W-1:0]     out_v_active_out,
  output logic                           out_neg_hsync,
  output logic                           out_neg_vsync,
  output logic [dtv_pkg::REFRESH_W-1:0]  out_refresh_mhz,
  output logic [dtv_pkg::FRAME_W-1:0]    out_frametime_ns
);

  typedef enum logic [3:0] {
    S_IDLE, S_CHECK, S_START, S_DIV, S_POST, S_PREP, S_MULF, S_OUT
  } state_t;

  typedef enum logic [1:0] { OP_Q, OP_A, OP_R, OP_F } op_t;

  state_t state_r, state_nxt;
  op_t    op_r, op_nxt;

  logic [1:0]  kind_r, kind_nxt;
  logic [7:0]  dsi_r, dsi_nxt;
  logic [dtv_pkg::REFRESH_W-1:0] refresh_r, refresh_nxt;

  // latched request
  logic [dtv_pkg::PERIOD_W-1:0] per_r;
  logic [dtv_pkg::TIM_W-1:0] hsw_r, vsw_r, hbp_r, vbp_r, hact_r, yres_r, hfp_r, vfp_r;
  logic hhi_r, vhi_r, st_r;

  // result
  logic [1:0]                    status_r, status_nxt;
  logic [dtv_pkg::PCLK_W-1:0]    pclk_r, pclk_nxt;
  logic [dtv_pkg::TIM_W-1:0]     href_r, href_nxt, vref_r, vref_nxt;
  logic [dtv_pkg::VACT_W-1:0]    vact_r, vact_nxt;
  logic [dtv_pkg::FRAME_W-1:0]   frame_r, frame_nxt;

  logic [14:0] htot_r, htot_nxt;
  logic [15:0] vtot_r, vtot_nxt;
  logic [60:0] num_r, num_nxt;

  // divider
  logic [dtv_pkg::DIVD_W-1:0] quo_r, quo_nxt;
  logic [dtv_pkg::DIVS_W:0]   rem_r, rem_nxt;
  logic [dtv_pkg::DIVS_W-1:0] dvs_r, dvs_nxt;
  logic [dtv_pkg::CNT_W-1:0]  cnt_r, cnt_nxt;

  logic [dtv_pkg::DIVS_W:0]   trial, diff;
  logic                       ge;

  // timing checks
  logic signed [16:0] hsw_s, vsw_s, hbp_s, vbp_s, hfp_s, vfp_s, hact_s, yres_s;
  logic signed [16:0] lo_s, hr_s, vr_s, href_s, vref_s;
  logic               pre_ok, tim_ok;
  logic [39:0]        pclk_base;
  logic [50:0]        a_k;

  always_comb begin
    hsw_s  = 17'(hsw_r);
    vsw_s  = 17'(vsw_r);
    hbp_s  = 17'(hbp_r);
    vbp_s  = 17'(vbp_r);
    hfp_s  = 17'(hfp_r);
    vfp_s  = 17'(vfp_r);
    hact_s = 17'(hact_r);
    yres_s = 17'(yres_r);

    lo_s = (hsw_s + hbp_s <= 17'sd11) ? 17'sd12 - hsw_s - hbp_s : 17'sd0;
    hr_s = ((hfp_s - 17'sd1 > lo_s) && lo_s[0]) ? lo_s + 17'sd1 : lo_s;
    vr_s = (vsw_s + vbp_s == 17'sd0) ? 17'sd2 : 17'sd1;
    if (vfp_s < vr_s + 17'sd1) begin
      vr_s = vfp_s - 17'sd1;
    end

    if (kind_r == dtv_pkg::KIND_HDMI) begin
      href_s = 17'sd1;
      vref_s = 17'sd1;
      pre_ok = 1'b1;
    end else begin
      href_s = hr_s;
      vref_s = vr_s;
      pre_ok = (lo_s < hfp_s) && (hsw_s >= 17'sd1) && (hact_s >= 17'sd16) &&
               (vsw_s >= 17'sd1) && (yres_s >= 17'sd16);
    end

    tim_ok = pre_ok &&
             (href_s + hsw_s + hbp_s > 17'(dtv_pkg::H_MIN_SUM)) &&
             (vref_s + vsw_s + vbp_s > 17'sd1) &&
             (vfp_s + vsw_s + vbp_s > 17'sd1) &&
             (vsw_s >= 17'sd1) && (hsw_s >= 17'sd1) &&
             (vref_s >= 17'sd1) && (href_s >= 17'sd0) &&
             (vfp_s >= vref_s + 17'sd1) && (hfp_s >= href_s + 17'sd1) &&
             (hact_s >= 17'(dtv_pkg::ACT_MIN)) && (yres_s >= 17'(dtv_pkg::ACT_MIN));
  end

  // one restoring step
  always_comb begin
    trial = {rem_r[dtv_pkg::DIVS_W-1:0], quo_r[dtv_pkg::DIVD_W-1]};
    ge    = trial >= {1'b0, dvs_r};
    diff  = trial - {1'b0, dvs_r};
  end

  assign pclk_base = 40'(quo_r[29:0]) * 40'(dtv_pkg::MILLI);
  assign a_k       = 51'(quo_r[40:0]) * 51'(dtv_pkg::MILLI);

  always_comb begin
    state_nxt   = state_r;
    op_nxt      = op_r;
    kind_nxt    = kind_r;
    dsi_nxt     = dsi_r;
    refresh_nxt = refresh_r;
    status_nxt  = status_r;
    pclk_nxt    = pclk_r;
    href_nxt    = href_r;
    vref_nxt    = vref_r;
    vact_nxt    = vact_r;
    frame_nxt   = frame_r;
    htot_nxt    = htot_r;
    vtot_nxt    = vtot_r;
    num_nxt     = num_r;
    quo_nxt     = quo_r;
    rem_nxt     = rem_r;
    dvs_nxt     = dvs_r;
    cnt_nxt     = cnt_r;

    if (cfg_we) begin
      case (cfg_index)
        dtv_pkg::CFG_KIND: kind_nxt = cfg_wdata[1:0];
        dtv_pkg::CFG_DSI:  dsi_nxt  = cfg_wdata;
        default: ;
      endcase
    end

    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          state_nxt = S_CHECK;
        end
      end
      S_CHECK: begin
        href_nxt = href_s[dtv_pkg::TIM_W-1:0];
        vref_nxt = vref_s[dtv_pkg::TIM_W-1:0];
        if (st_r) begin
          vact_nxt = {yres_r, 1'b0} + 16'(vsw_r) + 16'(vbp_r) + 16'(vfp_r);
          vtot_nxt = {yres_r, 1'b0} + {vsw_r, 1'b0} + {vbp_r, 1'b0} + {vfp_r, 1'b0};
        end else begin
          vact_nxt = 16'(yres_r);
          vtot_nxt = 16'(yres_r) + 16'(vsw_r) + 16'(vbp_r) + 16'(vfp_r);
        end
        htot_nxt = 15'(hact_r) + 15'(hfp_r) + 15'(hbp_r) + 15'(hsw_r);
        if (per_r == '0) begin
          status_nxt = dtv_pkg::ST_ZERO;
          state_nxt  = S_OUT;
        end else if (!tim_ok) begin
          status_nxt = dtv_pkg::ST_BAD;
          state_nxt  = S_OUT;
        end else begin
          status_nxt = dtv_pkg::ST_OK;
          op_nxt     = OP_Q;
          state_nxt  = S_START;
        end
      end
      S_START: begin
        // dividend left-aligned so that only its own bits are stepped through
        rem_nxt = '0;
        case (op_r)
          OP_Q: begin
            quo_nxt = {dtv_pkg::NS_PER_S, 34'd0};
            dvs_nxt = 41'(per_r);
            cnt_nxt = 6'(dtv_pkg::LEN_Q);
          end
          OP_A: begin
            quo_nxt = {pclk_r, 23'd0};
            dvs_nxt = 41'(htot_r);
            cnt_nxt = 6'(dtv_pkg::LEN_A);
          end
          OP_R: begin
            quo_nxt = {num_r[50:0], 13'd0};
            dvs_nxt = 41'(vtot_r);
            cnt_nxt = 6'(dtv_pkg::LEN_R);
          end
          default: begin
            quo_nxt = {num_r, 3'd0};
            dvs_nxt = pclk_r;
            cnt_nxt = 6'(dtv_pkg::LEN_F);
          end
        endcase
        state_nxt = S_DIV;
      end
      S_DIV: begin
        rem_nxt = ge ? diff : trial;
        quo_nxt = {quo_r[dtv_pkg::DIVD_W-2:0], ge};
        cnt_nxt = cnt_r - 6'd1;
        if (cnt_r == 6'd1) begin
          state_nxt = S_POST;
        end
      end
      S_POST: begin
        case (op_r)
          OP_Q: begin
            pclk_nxt = st_r ? {pclk_base, 1'b0} : {1'b0, pclk_base};
            if (kind_r == dtv_pkg::KIND_RGB) begin
              op_nxt    = OP_A;
              state_nxt = S_START;
            end else begin
              if (kind_r == dtv_pkg::KIND_DSI) begin
                refresh_nxt = 31'(dsi_r) * 31'(dtv_pkg::MILLI);
              end
              state_nxt = S_PREP;
            end
          end
          OP_A: begin
            num_nxt   = 61'(a_k);
            op_nxt    = OP_R;
            state_nxt = S_START;
          end
          OP_R: begin
            refresh_nxt = (quo_r[50:31] != '0) ? dtv_pkg::REFRESH_MAX : quo_r[30:0];
            state_nxt   = S_PREP;
          end
          default: begin
            frame_nxt = quo_r[dtv_pkg::FRAME_W-1:0];
            state_nxt = S_OUT;
          end
        endcase
      end
      S_PREP: begin
        num_nxt   = 61'(31'(htot_r) * 31'(vtot_r));
        state_nxt = S_MULF;
      end
      S_MULF: begin
        num_nxt   = 61'(num_r[30:0]) * 61'(dtv_pkg::NS_PER_S);
        op_nxt    = OP_F;
        state_nxt = S_START;
      end
      S_OUT: begin
        if (!out_stall) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= S_IDLE;
      op_r      <= OP_Q;
      kind_r    <= dtv_pkg::KIND_RGB;
      dsi_r     <= 8'd60;
      refresh_r <= '0;
    end else begin
      state_r   <= state_nxt;
      op_r      <= op_nxt;
      kind_r    <= kind_nxt;
      dsi_r     <= dsi_nxt;
      refresh_r <= refresh_nxt;
    end
    status_r <= status_nxt;
    pclk_r   <= pclk_nxt;
    href_r   <= href_nxt;
    vref_r   <= vref_nxt;
    vact_r   <= vact_nxt;
    frame_r  <= frame_nxt;
    htot_r   <= htot_nxt;
    vtot_r   <= vtot_nxt;
    num_r    <= num_nxt;
    quo_r    <= quo_nxt;
    rem_r    <= rem_nxt;
    dvs_r    <= dvs_nxt;
    cnt_r    <= cnt_nxt;
    if (state_r == S_IDLE && in_valid) begin
      per_r  <= in_pixel_period_ps;
      hsw_r  <= in_hsync_len;
      vsw_r  <= in_vsync_len;
      hbp_r  <= in_left_margin;
      vbp_r  <= in_upper_margin;
      hact_r <= in_x_res;
      yres_r <= in_y_res;
      hfp_r  <= in_right_margin;
      vfp_r  <= in_lower_margin;
      hhi_r  <= in_hsync_high_active;
      vhi_r  <= in_vsync_high_active;
      st_r   <= in_stereo;
    end
  end

  logic res_ok;
  assign res_ok = (status_r == dtv_pkg::ST_OK);

  assign in_stall         = (state_r != S_IDLE);
  assign out_valid        = (state_r == S_OUT);
  assign out_status       = status_r;
  assign out_pclk_hz      = res_ok ? pclk_r : '0;
  assign out_h_ref        = res_ok ? href_r : '0;
  assign out_v_ref        = res_ok ? vref_r : '0;
  assign out_v_active_out = res_ok ? vact_r : '0;
  assign out_neg_hsync    = res_ok & ~hhi_r;
  assign out_neg_vsync    = res_ok & ~vhi_r;
  assign out_refresh_mhz  = refresh_r;
  assign out_frametime_ns = res_ok ? frame_r : '0;

endmodule

FILE: tb/tb_display_timing_validator_unit.sv
// testbench for display_timing_validator_unit: directed table of modes, then random modes
// depends on dtv_pkg and display_timing_validator_unit; results checked against a local model
module tb_display_timing_validator_unit;

  localparam int N_RANDOM = 1800;

  // short aliases for the directed table
  localparam logic [1:0] K_RGB   = dtv_pkg::KIND_RGB;
  localparam logic [1:0] K_HDMI  = dtv_pkg::KIND_HDMI;
  localparam logic [1:0] K_DSI   = dtv_pkg::KIND_DSI;
  localparam logic [1:0] K_OTHER = dtv_pkg::KIND_OTHER;
  localparam logic [1:0] S_OK    = dtv_pkg::ST_OK;
  localparam logic [1:0] S_ZERO  = dtv_pkg::ST_ZERO;
  localparam logic [1:0] S_BAD   = dtv_pkg::ST_BAD;

  typedef struct {
    logic [dtv_pkg::PERIOD_W-1:0] period;
    logic [dtv_pkg::TIM_W-1:0]    hsw, vsw, hbp, vbp, xres, yres, hfp, vfp;
    logic                         hhigh, vhigh, stereo;
  } mode_t;

  typedef struct {
    logic [1:0]                    status;
    logic [dtv_pkg::PCLK_W-1:0]    pclk;
    logic [dtv_pkg::TIM_W-1:0]     href, vref;
    logic [dtv_pkg::VACT_W-1:0]    vact;
    logic                          nhs, nvs;
    logic [dtv_pkg::REFRESH_W-1:0] refresh;
    logic [dtv_pkg::FRAME_W-1:0]   frame;
  } timing_t;

  // directed row: output kind, mode, and a typed status where it is obvious
  typedef struct {
    logic [1:0] kind;
    mode_t      m;
    logic       known;
    logic [1:0] status;
  } row_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_we = 1'b0;
  logic cfg_index = dtv_pkg::CFG_KIND;
  logic [7:0] cfg_wdata = '0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic [dtv_pkg::PERIOD_W-1:0] in_pixel_period_ps = '0;
  logic [dtv_pkg::TIM_W-1:0] in_hsync_len = '0, in_vsync_len = '0, in_left_margin = '0;
  logic [dtv_pkg::TIM_W-1:0] in_upper_margin = '0, in_x_res = '0, in_y_res = '0;
  logic [dtv_pkg::TIM_W-1:0] in_right_margin = '0, in_lower_margin = '0;
  logic in_hsync_high_active = 1'b0, in_vsync_high_active = 1'b0, in_stereo = 1'b0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic [1:0] out_status;
  logic [dtv_pkg::PCLK_W-1:0] out_pclk_hz;
  logic [dtv_pkg::TIM_W-1:0] out_h_ref, out_v_ref;
  logic [dtv_pkg::VACT_W-1:0] out_v_active_out;
  logic out_neg_hsync, out_neg_vsync;
  logic [dtv_pkg::REFRESH_W-1:0] out_refresh_mhz;
  logic [dtv_pkg::FRAME_W-1:0] out_frametime_ns;

  display_timing_validator_unit dut (.*);

  always #10 clk = ~clk;

  // local copy of configuration and state
  logic [1:0]                    kind_q = dtv_pkg::KIND_RGB;
  logic [7:0]                    dsi_hz_q = 8'd60;
  logic [dtv_pkg::REFRESH_W-1:0] refresh_q = '0;

  timing_t pending_results[$];
  int      n_errors = 0;
  bit      quiet = 1'b0;
  bit      long_hold_req = 1'b0;

  task automatic report(string what, longint unsigned got, longint unsigned want);
    $display("mismatch %s: got %0d expected %0d", what, got, want);
    n_errors++;
  endtask

  function automatic timing_t predict_timing(mode_t m);
    timing_t r;
    int hsw, vsw, hbp, vbp, hact, yres, hfp, vfp, href, vref, vact, lo, hi;
    bit ok;
    longint unsigned pclk, htot, vtot, rr;
    r = '{default: '0};
    hsw = int'(m.hsw); vsw = int'(m.vsw); hbp = int'(m.hbp); vbp = int'(m.vbp);
    hact = int'(m.xres); yres = int'(m.yres); hfp = int'(m.hfp); vfp = int'(m.vfp);
    vact = yres;
    href = 0; vref = 0;
    r.refresh = refresh_q;
    if (m.period == 0) begin
      r.status = dtv_pkg::ST_ZERO;
      return r;
    end
    pclk = (64'd1000000000 / 64'(m.period)) * 64'd1000;
    ok = 1'b1;
    if (kind_q == dtv_pkg::KIND_HDMI) begin
      href = 1;
      vref = 1;
    end else begin
      lo = 0;
      hi = hfp - 1;
      if (hsw + hbp <= 11) lo = 12 - hsw - hbp;
      if (lo > hi || hsw < 1 || hact < 16) ok = 1'b0;
      href = (hi > lo && lo[0]) ? lo + 1 : lo;
      vref = 1;
      if (1 + vsw + vbp <= 1) vref = 2 - vsw - vbp;
      if (vfp < vref + 1) vref = vfp - 1;
      if (vsw < 1 || vact < 16) ok = 1'b0;
    end
    // the eleven constraints
    if (href + hsw + hbp <= 11 || vref + vsw + vbp <= 1 || vfp + vsw + vbp <= 1) ok = 1'b0;
    if (vsw < 1 || hsw < 1 || vref < 1 || href < 0) ok = 1'b0;
    if (vfp < vref + 1 || hfp < href + 1 || hact < 16 || vact < 16) ok = 1'b0;
    if (!ok) begin
      r.status = dtv_pkg::ST_BAD;
      return r;
    end
    if (m.stereo) begin
      pclk = pclk * 64'd2;
      vact = yres * 2 + vsw + vbp + vfp;
    end
    htot = 64'(hact + hfp + hbp + hsw);
    vtot = 64'(vact + vfp + vbp + vsw);
    if (kind_q == dtv_pkg::KIND_RGB) begin
      rr = (pclk / htot) * 64'd1000 / vtot;
      refresh_q = (rr > 64'(dtv_pkg::REFRESH_MAX)) ? dtv_pkg::REFRESH_MAX
                                                  : rr[dtv_pkg::REFRESH_W-1:0];
    end else if (kind_q == dtv_pkg::KIND_DSI) begin
      refresh_q = 31'(dsi_hz_q) * 31'd1000;
    end
    r.status  = dtv_pkg::ST_OK;
    r.pclk    = pclk[dtv_pkg::PCLK_W-1:0];
    r.href    = href[dtv_pkg::TIM_W-1:0];
    r.vref    = vref[dtv_pkg::TIM_W-1:0];
    r.vact    = vact[dtv_pkg::VACT_W-1:0];
    r.nhs     = ~m.hhigh;
    r.nvs     = ~m.vhigh;
    r.refresh = refresh_q;
    rr        = htot * vtot * 64'd1000000000 / pclk;
    r.frame   = rr[dtv_pkg::FRAME_W-1:0];
    return r;
  endfunction

  // waits until the unit is idle, then writes one register
  task automatic write_reg(logic idx, logic [7:0] val);
    wait (pending_results.size() == 0);
    repeat (4) @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    if (idx == dtv_pkg::CFG_KIND) kind_q = val[1:0];
    else dsi_hz_q = val;
  endtask

  // offers one mode request and waits for it to be taken
  task automatic send_mode(mode_t m, bit known, logic [1:0] st);
    int gap;
    timing_t e;
    gap = quiet ? 0 : $urandom_range(0, 11);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid             <= 1'b1;
    in_pixel_period_ps   <= m.period;
    in_hsync_len         <= m.hsw;
    in_vsync_len         <= m.vsw;
    in_left_margin       <= m.hbp;
    in_upper_margin      <= m.vbp;
    in_x_res             <= m.xres;
    in_y_res             <= m.yres;
    in_right_margin      <= m.hfp;
    in_lower_margin      <= m.vfp;
    in_hsync_high_active <= m.hhigh;
    in_vsync_high_active <= m.vhigh;
    in_stereo            <= m.stereo;
    do @(posedge clk); while (in_stall);
    e = predict_timing(m);
    if (known) e.status = st;
    pending_results.push_back(e);
  endtask

  function automatic mode_t random_mode();
    mode_t m;
    int sel;
    sel = $urandom_range(0, 99);
    m.period = 20'($urandom_range(1, 60000));
    m.hsw  = 13'($urandom_range(1, 150));
    m.hbp  = 13'($urandom_range(0, 200));
    m.hfp  = 13'($urandom_range(1, 200));
    m.vsw  = 13'($urandom_range(1, 12));
    m.vbp  = 13'($urandom_range(0, 40));
    m.vfp  = 13'($urandom_range(1, 30));
    m.xres = 13'($urandom_range(16, 2000));
    m.yres = 13'($urandom_range(16, 1200));
    m.hhigh  = 1'($urandom_range(0, 1));
    m.vhigh  = 1'($urandom_range(0, 1));
    m.stereo = 1'($urandom_range(0, 1));
    if (sel < 8) begin
      // noise over the full field widths
      m.period = 20'($urandom);
      {m.hsw, m.vsw, m.hbp, m.vbp} = 52'({$urandom, $urandom});
      {m.xres, m.yres, m.hfp, m.vfp} = 52'({$urandom, $urandom});
    end else if (sel < 14) begin
      m.period = 20'($urandom_range(1, 20'hFFFFF));
      m.xres = 13'($urandom_range(16, 8191));
      m.yres = 13'($urandom_range(16, 8191));
      m.hfp  = 13'($urandom_range(1, 8191));
      m.vfp  = 13'($urandom_range(1, 8191));
    end else if (sel < 17) begin
      m.period = '0;
    end else if (sel < 22) begin
      // broken: one constraint out of range
      case ($urandom_range(0, 4))
        0: m.hsw = '0;
        1: m.vsw = '0;
        2: m.xres = 13'($urandom_range(0, 15));
        3: m.yres = 13'($urandom_range(0, 15));
        default: m.hfp = '0;
      endcase
    end
    return m;
  endfunction

  // result check
  always @(posedge clk) begin
    timing_t e;
    if (rst_n && out_valid && !out_stall) begin
      if (pending_results.size() == 0) begin
        $display("unexpected result with status %0d", out_status);
        n_errors++;
      end else begin
        e = pending_results.pop_front();
        if (out_status !== e.status) report("status", out_status, e.status);
        if (out_pclk_hz !== e.pclk) report("pclk_hz", out_pclk_hz, e.pclk);
        if (out_h_ref !== e.href) report("h_ref", out_h_ref, e.href);
        if (out_v_ref !== e.vref) report("v_ref", out_v_ref, e.vref);
        if (out_v_active_out !== e.vact) report("vact_out", out_v_active_out, e.vact);
        if (out_neg_hsync !== e.nhs) report("neg_hsync", out_neg_hsync, e.nhs);
        if (out_neg_vsync !== e.nvs) report("neg_vsync", out_neg_vsync, e.nvs);
        if (out_refresh_mhz !== e.refresh) report("refresh", out_refresh_mhz, e.refresh);
        if (out_frametime_ns !== e.frame) report("frametime", out_frametime_ns, e.frame);
      end
    end
  end

  // receiver: random stall before each result, plus one long hold-off on request
  initial begin
    int hold;
    hold = 0;
    forever begin
      @(posedge clk);
      if (long_hold_req) begin
        long_hold_req = 1'b0;
        hold = 600;
      end else if (out_valid && !out_stall) begin
        hold = quiet ? 0 : $urandom_range(0, 11);
      end else if (hold > 0) begin
        hold--;
      end
      out_stall <= (hold > 0);
    end
  end

  initial begin
    #100_000_000;
    $display("tb_display_timing_validator_unit: errors");
    $finish;
  end

  initial begin
    row_t rows[$];
    mode_t m;
    int k;
    logic [1:0] kinds[8];
    logic [7:0] rates[8];

    // kind, {period, hsw, vsw, hbp, vbp, xres, yres, hfp, vfp, hh, vh, stereo}, known, status
    rows = '{
      '{K_RGB,   '{0, 44, 5, 148, 36, 1920, 1080, 88, 4, 1, 1, 0}, 1'b1, S_ZERO},
      '{K_RGB,   '{6734, 44, 5, 148, 36, 1920, 1080, 88, 4, 1, 1, 0}, 1'b0, S_OK},
      '{K_RGB,   '{6734, 44, 5, 148, 36, 1920, 1080, 88, 4, 0, 0, 1}, 1'b0, S_OK},
      '{K_RGB,   '{6734, 0, 5, 148, 36, 1920, 1080, 88, 4, 1, 1, 0}, 1'b1, S_BAD},
      '{K_RGB,   '{6734, 44, 0, 148, 36, 1920, 1080, 88, 4, 1, 1, 0}, 1'b1, S_BAD},
      '{K_RGB,   '{6734, 44, 5, 148, 36, 15, 1080, 88, 4, 1, 1, 0}, 1'b1, S_BAD},
      '{K_RGB,   '{6734, 44, 5, 148, 36, 1920, 15, 88, 4, 1, 1, 0}, 1'b1, S_BAD},
      '{K_RGB,   '{6734, 44, 5, 148, 36, 1920, 1080, 0, 4, 1, 1, 0}, 1'b1, S_BAD},
      '{K_RGB,   '{6734, 44, 5, 148, 36, 1920, 1080, 88, 1, 1, 1, 0}, 1'b1, S_BAD},
      '{K_RGB,   '{6734, 1, 5, 0, 36, 640, 480, 20, 4, 0, 1, 0}, 1'b0, S_OK},
      '{K_RGB,   '{1, 1, 1, 11, 0, 16, 16, 1, 2, 1, 0, 1}, 1'b0, S_OK},
      '{K_RGB,   '{20'hFFFFF, 8191, 8191, 8191, 8191, 8191, 8191, 8191, 8191, 1, 1, 1},
        1'b0, S_OK},
      '{K_RGB,   '{20'hFFFFF, 8191, 8191, 8191, 8191, 8191, 8191, 8191, 8191, 0, 0, 0},
        1'b0, S_OK},
      '{K_HDMI,  '{6734, 44, 5, 148, 36, 1920, 1080, 0, 4, 1, 1, 0}, 1'b1, S_BAD},
      '{K_HDMI,  '{6734, 44, 5, 148, 36, 1920, 1080, 88, 4, 1, 1, 1}, 1'b0, S_OK},
      '{K_HDMI,  '{0, 44, 5, 148, 36, 1920, 1080, 88, 4, 1, 1, 0}, 1'b1, S_ZERO},
      '{K_DSI,   '{15000, 10, 2, 20, 8, 720, 1280, 30, 10, 0, 0, 0}, 1'b0, S_OK},
      '{K_DSI,   '{15000, 10, 2, 20, 8, 720, 1280, 30, 10, 1, 0, 1}, 1'b0, S_OK},
      '{K_OTHER, '{15000, 10, 2, 20, 8, 720, 1280, 30, 10, 0, 1, 0}, 1'b0, S_OK},
      '{K_OTHER, '{15000, 10, 2, 20, 8, 720, 1280, 30, 0, 0, 1, 0}, 1'b1, S_BAD}
    };

    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (rows[i]) begin
      if (rows[i].kind != kind_q) begin
        in_valid <= 1'b0;
        write_reg(dtv_pkg::CFG_KIND, {6'd0, rows[i].kind});
      end
      send_mode(rows[i].m, rows[i].known, rows[i].status);
    end

    kinds = '{K_RGB, K_DSI, K_HDMI, K_DSI, K_OTHER, K_RGB, K_DSI, K_RGB};
    rates = '{8'd60, 8'd0, 8'd255, 8'd255, 8'd30, 8'd120, 8'($urandom), 8'd60};
    for (int p = 0; p < 8; p++) begin
      in_valid <= 1'b0;
      write_reg(dtv_pkg::CFG_KIND, {6'd0, kinds[p]});
      write_reg(dtv_pkg::CFG_DSI, rates[p]);
      quiet = (p == 5);
      for (k = 0; k < N_RANDOM / 8; k++) begin
        if (p == 2 && k == 40) long_hold_req = 1'b1;
        if (p == 3 && k == 60) begin
          // sender pauses until every result is back
          in_valid <= 1'b0;
          wait (pending_results.size() == 0);
          @(posedge clk);
        end
        m = random_mode();
        send_mode(m, 1'b0, S_OK);
      end
    end
    in_valid <= 1'b0;

    wait (pending_results.size() == 0);
    repeat (250) @(posedge clk);
    if (n_errors == 0) begin
      $display("tb_display_timing_validator_unit: clean");
    end else begin
      $display("tb_display_timing_validator_unit: errors");
    end
    $finish;
  end

endmodule
